// File: sv/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// types and constants shared by the rgb888 to yuv420 converter
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    localparam logic [7:0] Y_R = 8'd77;
    localparam logic [7:0] Y_G = 8'd150;
    localparam logic [7:0] Y_B = 8'd29;

    localparam logic [31:0] C_OFFSET = 32'd32768;
    localparam logic [31:0] C_FULL   = 32'd128;
    localparam logic [31:0] U_R      = 32'd43;
    localparam logic [31:0] U_G      = 32'd85;
    localparam logic [31:0] V_G      = 32'd107;
    localparam logic [31:0] V_B      = 32'd21;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] u_chroma;
        logic [7:0] v_chroma;
        logic       frame_end;
    } t_yuv;

    typedef struct packed {
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_sums;

    typedef struct packed {
        logic col_odd;
        logic col_last;
        logic row_odd;
        logic row_last;
    } t_pos_flags;

endpackage

// File: sv/rgb888_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// rgb888_to_yuv420_converter_top
// result word runs from the accept edge through the pixel register and then the result register
// throughput: one pixel per cycle while i_out_stall is low, set by the single pixel and result registers
// line store read is issued at accept and lands with the pixel register
// synchronous reset clears counters, pair sums and valids, size to 1920x1080
// line store is not cleared at reset
// ----------------------------------------------------------------------------
module rgb888_to_yuv420_converter_top #(
    parameter int MAX_WIDTH  = 7680,
    parameter int MAX_HEIGHT = 4320
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rgb2yuv_pkg::t_pix                   i_in_pix,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rgb2yuv_pkg::t_yuv                   o_out_yuv
);
    import rgb2yuv_pkg::*;

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = ($clog2(DEPTH) > 1) ? $clog2(DEPTH) : 1;

    logic          accept;
    t_pos_flags    flags;
    logic [AW-1:0] slot;
    t_sums         top_sums;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_sums         wr_data;

    assign o_cfg_ready = 1'b1;

    rgb2yuv_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_flags     (flags),
        .o_slot      (slot)
    );

    rgb2yuv_line #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (slot),
        .o_rd_data (top_sums),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    rgb2yuv_core #(
        .AW (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_pix    (i_in_pix),
        .o_accept    (accept),
        .i_flags     (flags),
        .i_slot      (slot),
        .i_top       (top_sums),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_yuv   (o_out_yuv)
    );

endmodule

// File: sv/rgb2yuv_pos.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pos
// size registers and raster position counters
// ----------------------------------------------------------------------------
module rgb2yuv_pos #(
    parameter int MAX_WIDTH  = 7680,
    parameter int MAX_HEIGHT = 4320,
    parameter int AW         = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_accept,
    output rgb2yuv_pkg::t_pos_flags             o_flags,
    output logic [AW-1:0]                       o_slot
);
    import rgb2yuv_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                        $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SH = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                        $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;

    logic [SW-1:0] w_eff;
    logic [SH-1:0] h_eff;
    logic [SW:0]   col_nx;
    logic [SH:0]   row_nx;
    logic          col_last;
    logic          row_last;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SW'(1);
        end else if (SW'(r_frame_width) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = SH'(1);
        end else if (SH'(r_frame_height) > SH'(MAX_HEIGHT)) begin
            h_eff = SH'(MAX_HEIGHT);
        end else begin
            h_eff = SH'(r_frame_height);
        end
        col_nx   = (SW + 1)'(r_col) + (SW + 1)'(1);
        row_nx   = (SH + 1)'(r_row) + (SH + 1)'(1);
        col_last = col_nx >= (SW + 1)'(w_eff);
        row_last = row_nx >= (SH + 1)'(h_eff);
    end

    assign o_flags.col_odd  = r_col[0];
    assign o_flags.col_last = col_last;
    assign o_flags.row_odd  = r_row[0];
    assign o_flags.row_last = row_last;
    assign o_slot           = AW'(r_col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : RW'(row_nx);
                end else begin
                    r_col <= CW'(col_nx);
                end
            end
        end
    end

endmodule

// File: sv/rgb2yuv_line.sv
// ----------------------------------------------------------------------------
// rgb2yuv_line
// line store for the pair sums of the even row, registered read with bypass
// ----------------------------------------------------------------------------
module rgb2yuv_line #(
    parameter int DEPTH = 3840,
    parameter int AW    = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output rgb2yuv_pkg::t_sums    o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  rgb2yuv_pkg::t_sums    i_wr_data
);
    import rgb2yuv_pkg::*;

    t_sums mem [DEPTH];
    t_sums r_rd_q;
    t_sums r_byp_data;
    logic  r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q     <= mem[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_q;

endmodule

// File: sv/rgb2yuv_core.sv
// ----------------------------------------------------------------------------
// rgb2yuv_core
// pixel register, luma and block chroma math, result register
// ----------------------------------------------------------------------------
module rgb2yuv_core #(
    parameter int AW = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  rgb2yuv_pkg::t_pix        i_in_pix,
    output logic                     o_accept,
    input  rgb2yuv_pkg::t_pos_flags  i_flags,
    input  logic [AW-1:0]            i_slot,
    input  rgb2yuv_pkg::t_sums       i_top,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output rgb2yuv_pkg::t_sums       o_wr_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output rgb2yuv_pkg::t_yuv        o_out_yuv
);
    import rgb2yuv_pkg::*;

    logic       r_s1_vld;
    t_pix       r_s1_pix;
    t_pos_flags r_s1_flags;
    logic [AW-1:0] r_s1_slot;
    t_sums      r_pair;
    logic       r_out_vld;
    t_yuv       r_out;

    logic  out_free;
    logic  s1_adv;
    t_sums n_pair;
    t_yuv  n_out;
    logic  blk_col;
    logic  blk_row;
    logic [15:0] y_sum;
    logic [9:0]  sr, sg, sb;
    logic [9:0]  ar, ag, ab;
    logic [1:0]  sh;
    logic [31:0] e_u, e_v;
    logic [23:0] q_u, q_v;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign o_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        y_sum = 16'(Y_R * r_s1_pix.red) + 16'(Y_G * r_s1_pix.green)
              + 16'(Y_B * r_s1_pix.blue);

        if (r_s1_flags.col_odd) begin
            n_pair.red   = r_pair.red   + 9'(r_s1_pix.red);
            n_pair.green = r_pair.green + 9'(r_s1_pix.green);
            n_pair.blue  = r_pair.blue  + 9'(r_s1_pix.blue);
        end else begin
            n_pair.red   = 9'(r_s1_pix.red);
            n_pair.green = 9'(r_s1_pix.green);
            n_pair.blue  = 9'(r_s1_pix.blue);
        end

        blk_col = r_s1_flags.col_odd || r_s1_flags.col_last;
        blk_row = r_s1_flags.row_odd || r_s1_flags.row_last;

        sr = 10'(n_pair.red);
        sg = 10'(n_pair.green);
        sb = 10'(n_pair.blue);
        if (r_s1_flags.row_odd) begin
            sr = sr + 10'(i_top.red);
            sg = sg + 10'(i_top.green);
            sb = sb + 10'(i_top.blue);
        end
        sh = 2'(r_s1_flags.col_odd) + 2'(r_s1_flags.row_odd);
        ar = sr >> sh;
        ag = sg >> sh;
        ab = sb >> sh;

        e_u = C_OFFSET + C_FULL * 32'(ab) - U_R * 32'(ar) - U_G * 32'(ag);
        e_v = C_OFFSET + C_FULL * 32'(ar) - V_G * 32'(ag) - V_B * 32'(ab);
        q_u = e_u[31:8];
        q_v = e_v[31:8];

        n_out.luma         = y_sum[15:8];
        n_out.chroma_valid = blk_col && blk_row;
        n_out.u_chroma     = '0;
        n_out.v_chroma     = '0;
        if (blk_col && blk_row) begin
            n_out.u_chroma = (q_u > 24'd255) ? 8'hFF : q_u[7:0];
            n_out.v_chroma = (q_v > 24'd255) ? 8'hFF : q_v[7:0];
        end
        n_out.frame_end = r_s1_flags.col_last && r_s1_flags.row_last;
    end

    assign o_wr_en   = s1_adv && blk_col && !blk_row;
    assign o_wr_addr = r_s1_slot;
    assign o_wr_data = n_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pair    <= '0;
        end else begin
            if (o_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_adv) begin
                r_pair <= n_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_s1_pix   <= i_in_pix;
            r_s1_flags <= i_flags;
            r_s1_slot  <= i_slot;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_yuv   = r_out;

endmodule

// File: bench/tb_rgb888_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// tb_rgb888_to_yuv420_converter_top
// self-checking bench for the rgb888 to yuv420 converter: every pixel word is
// run through a bench-side model of luma and 2x2 block chroma, and each result
// word is compared field by field, in order, against the queue of expected words
// ----------------------------------------------------------------------------
module tb_rgb888_to_yuv420_converter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2yuv_pkg::*;

    localparam int MAX_W       = 7680;
    localparam int MAX_H       = 4320;
    localparam int LINE_SLOTS  = (MAX_W + 1) / 2;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYC  = 4;
    localparam int EXTREME_PIX = 21;
    localparam int PHASE_PIX   = 170;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_pix                  i_in_pix = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_yuv                  o_out_yuv;

    rgb888_to_yuv420_converter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_pix    (i_in_pix),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_yuv   (o_out_yuv)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the converter state
    logic [CFG_DATA_W-1:0] width_reg = RST_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] height_reg = RST_FRAME_HEIGHT;
    int    x_pos = 0;
    int    y_pos = 0;
    t_sums pair_acc = '0;
    t_sums line_store [LINE_SLOTS];

    t_yuv pending_yuv [$];
    int   err_count = 0;
    int   pix_accepted = 0;
    int   yuv_checked = 0;
    int   chroma_seen = 0;
    int   frames_seen = 0;
    int   cfg_writes = 0;
    int   quiet_cycles = 0;
    int   in_idle_pct = 0;
    int   out_stall_pct = 0;
    int   frame_cols = 1;
    int   frame_rows = 1;
    int   idle_in_pct [4] = '{0, 54, 0, 31};
    int   idle_out_pct [4] = '{0, 0, 54, 31};

    initial begin
        foreach (line_store[k]) line_store[k] = '0;
    end

    function automatic int sat_dim(input logic [CFG_DATA_W-1:0] v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return int'(v);
    endfunction

    function automatic int clip8(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic t_yuv predict_yuv(input t_pix p);
        t_yuv  want;
        t_sums above;
        int    w, h, slot, shift, sr, sg, sb, ar, ag, ab;
        logic  x_last, y_last, x_odd, y_odd;
        w      = sat_dim(width_reg, MAX_W);
        h      = sat_dim(height_reg, MAX_H);
        x_last = (x_pos + 1 >= w);
        y_last = (y_pos + 1 >= h);
        x_odd  = x_pos[0];
        y_odd  = y_pos[0];
        slot   = (x_pos >> 1) % LINE_SLOTS;
        want   = '0;
        want.luma = 8'(clip8((77 * int'(p.red) + 150 * int'(p.green)
                              + 29 * int'(p.blue)) >> 8));
        if (x_odd) begin
            pair_acc.red   = pair_acc.red + p.red;
            pair_acc.green = pair_acc.green + p.green;
            pair_acc.blue  = pair_acc.blue + p.blue;
        end else begin
            pair_acc.red   = {1'b0, p.red};
            pair_acc.green = {1'b0, p.green};
            pair_acc.blue  = {1'b0, p.blue};
        end
        if (x_odd || x_last) begin
            if (y_odd || y_last) begin
                sr = int'(pair_acc.red);
                sg = int'(pair_acc.green);
                sb = int'(pair_acc.blue);
                if (y_odd) begin
                    above = line_store[slot];
                    sr += int'(above.red);
                    sg += int'(above.green);
                    sb += int'(above.blue);
                end
                shift = int'(x_odd) + int'(y_odd);
                ar = sr >> shift;
                ag = sg >> shift;
                ab = sb >> shift;
                want.chroma_valid = 1'b1;
                want.u_chroma = 8'(clip8((32768 + 128 * ab - 43 * ar - 85 * ag) >>> 8));
                want.v_chroma = 8'(clip8((32768 + 128 * ar - 107 * ag - 21 * ab) >>> 8));
            end else begin
                line_store[slot] = pair_acc;
            end
        end
        want.frame_end = x_last && y_last;
        if (x_last) begin
            x_pos = 0;
            y_pos = y_last ? 0 : y_pos + 1;
        end else begin
            x_pos = x_pos + 1;
        end
        return want;
    endfunction

    // follows the register and pixel handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            cfg_writes++;
            if (i_cfg_index == CFG_FRAME_WIDTH) width_reg = i_cfg_data;
            else if (i_cfg_index == CFG_FRAME_HEIGHT) height_reg = i_cfg_data;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pix_accepted++;
            pending_yuv.push_back(predict_yuv(i_in_pix));
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at word %0d: %s got %0d expected %0d",
                 yuv_checked, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_yuv want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_yuv.size() == 0) begin
                report_mismatch("unexpected word, luma", o_out_yuv.luma, 0);
            end else begin
                want = pending_yuv.pop_front();
                if (o_out_yuv.luma != want.luma)
                    report_mismatch("luma", o_out_yuv.luma, want.luma);
                if (o_out_yuv.chroma_valid != want.chroma_valid)
                    report_mismatch("chroma_valid", o_out_yuv.chroma_valid,
                                    want.chroma_valid);
                if (o_out_yuv.u_chroma != want.u_chroma)
                    report_mismatch("u_chroma", o_out_yuv.u_chroma, want.u_chroma);
                if (o_out_yuv.v_chroma != want.v_chroma)
                    report_mismatch("v_chroma", o_out_yuv.v_chroma, want.v_chroma);
                if (o_out_yuv.frame_end != want.frame_end)
                    report_mismatch("frame_end", o_out_yuv.frame_end, want.frame_end);
            end
            if (o_out_yuv.chroma_valid) chroma_seen++;
            if (o_out_yuv.frame_end) frames_seen++;
            yuv_checked++;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d words outstanding",
                     QUIET_LIMIT, pending_yuv.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_pix rand_pix();
        t_pix p;
        p.red   = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        p.green = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        p.blue  = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        return p;
    endfunction

    // call right after a rising edge; valid stays up for a following word
    task automatic send_pix(input t_pix p);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_pix   <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // valid drops and a clock edge passes first, so the last accepted word is already queued
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_yuv.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        wait_quiet();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        i_cfg_valid <= 1'b0;
        frame_cols = sat_dim(CFG_DATA_W'(w), MAX_W);
        frame_rows = sat_dim(CFG_DATA_W'(h), MAX_H);
    endtask

    task automatic send_frames(input int n);
        repeat (n * frame_cols * frame_rows) send_pix(rand_pix());
    endtask

    // 3x3 frame: full block, right edge pair, bottom pair, lone corner pixel
    task automatic test_edge_blocks();
        logic [23:0] colors [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                    24'h00FF00, 24'h0000FF, 24'hFFFF00,
                                    24'h00FFFF, 24'hFF00FF, 24'h808080};
        in_idle_pct = 0;
        out_stall_pct = 0;
        set_frame(3, 3);
        foreach (colors[k]) send_pix(t_pix'(colors[k]));
    endtask

    task automatic test_zero_size();
        in_idle_pct = 54;
        out_stall_pct = 0;
        set_frame(0, 0);
        send_frames(2);
    endtask

    // size change while counters sit inside a frame
    task automatic test_resize_mid_frame();
        in_idle_pct = 0;
        out_stall_pct = 54;
        set_frame(4, 2);
        repeat (7) send_pix(rand_pix());
        set_frame(2, 2);
        send_pix(rand_pix());
        set_frame(1, 4);
        repeat (3) send_pix(rand_pix());
        set_frame(1, 2);
        send_pix(rand_pix());
    endtask

    // short run into each oversized or zero frame, then a 1x1 size ends it
    task automatic test_size_extremes();
        int w_set [4] = '{8191, 7680, 1, 0};
        int h_set [4] = '{2, 0, 8191, 4320};
        foreach (w_set[k]) begin
            in_idle_pct = idle_in_pct[k];
            out_stall_pct = idle_out_pct[k];
            set_frame(w_set[k], h_set[k]);
            repeat (EXTREME_PIX) send_pix(rand_pix());
            set_frame(1, 1);
            send_pix(rand_pix());
        end
    endtask

    task automatic test_random_frames();
        int phase_pix;
        int w, h, n;
        for (int ph = 0; ph < 4; ph++) begin
            in_idle_pct = idle_in_pct[ph];
            out_stall_pct = idle_out_pct[ph];
            phase_pix = 0;
            while (phase_pix < PHASE_PIX) begin
                w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                h = $urandom_range(0, 9);
                n = $urandom_range(1, 3);
                set_frame(w, h);
                send_frames(n);
                phase_pix += n * frame_cols * frame_rows;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_blocks();
        test_zero_size();
        test_resize_mid_frame();
        test_size_extremes();
        test_random_frames();
        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (pending_yuv.size() != 0)
            report_mismatch("words never produced", pending_yuv.size(), 0);
        $display("covered %0d pixels in %0d frames with %0d chroma blocks",
                 pix_accepted, frames_seen, chroma_seen);
        $display("%0d size register writes, %0d words checked, %0d mismatches",
                 cfg_writes, yuv_checked, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
